### rtl/core/chd_pkg.sv
package chd_pkg;

  // field widths of the stream payloads
  localparam int CENSUS_W  = 48;
  localparam int COST_W    = 6;
  localparam int DISP_W    = 13;
  localparam int COL_W     = 12;
  localparam int ROWLEN_W  = 13;
  localparam int FIRSTD_W  = 12;
  localparam int OUT_W     = 32;
  // wide enough for any row length and any disparity compared against a column
  localparam int LEN_W     = 14;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_DISP = 1'd1;

  localparam logic [ROWLEN_W-1:0] ROW_LENGTH_RST = 13'd3840;
  localparam logic [FIRSTD_W-1:0] FIRST_DISP_RST = 12'd0;
  localparam logic [COST_W-1:0]   COST_OFF_EDGE  = 6'd48;

  // set bits per nibble
  localparam logic [2:0] NIB_BITS [16] = '{
    3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
    3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4
  };

  typedef enum logic {
    ST_TAKE,
    ST_EMIT
  } seq_state_t;

  typedef struct packed {
    logic [COL_W-1:0]  pixel_column;
    logic [DISP_W-1:0] disparity;
    logic [COST_W-1:0] match_cost;
    logic              last_of_pixel;
  } result_t;

  // popcount of a census word as a shallow adder tree
  function automatic logic [COST_W-1:0] popcount48(input logic [CENSUS_W-1:0] v);
    logic [3:0] pair [6];
    logic [4:0] half0;
    logic [4:0] half1;
    for (int i = 0; i < 6; i++) begin
      pair[i] = 4'(NIB_BITS[v[8*i +: 4]]) + 4'(NIB_BITS[v[8*i+4 +: 4]]);
    end
    half0 = 5'(pair[0]) + 5'(pair[1]) + 5'(pair[2]);
    half1 = 5'(pair[3]) + 5'(pair[4]) + 5'(pair[5]);
    return COST_W'(half0) + COST_W'(half1);
  endfunction

endpackage

### rtl/core/chd_ram.sv
module chd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/chd_outbuf.sv
module chd_outbuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  chd_pkg::result_t push_data,
  output logic             out_valid,
  input  logic             out_ready,
  output chd_pkg::result_t out_data,
  output logic [1:0]       count
);
  import chd_pkg::*;

  result_t slot [2];
  logic    wr_ptr;
  logic    rd_ptr;
  logic    pop;

  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  assign out_data  = slot[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // result slots
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule

### rtl/core/census_hamming_disparity_cost_unit.sv
// right row item: written straight into the row store when taken, no result
// left pixel item: one row store read and one cost per disparity offset, one per cycle while the output buffer has room
// first cost of a pixel: issued in ST_EMIT, then registered in the read stage and in the output buffer
// results drain through a two-entry output buffer, so a new request is taken while they wait
// reset (synchronous, active high) clears column counter, phase, sequencer and buffer,
// sets row_length to 3840 and first_disparity to 0; the row store is not cleared
module census_hamming_disparity_cost_unit #(
  parameter int MAX_ROW_WIDTH         = 4096,
  parameter int DISPARITIES_PER_PIXEL = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [chd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [chd_pkg::ROWLEN_W-1:0]     cfg_data,
  // census input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [chd_pkg::CENSUS_W-1:0]     s_axis_tdata,  // [47:0] census_word
  // cost output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [5:0] match_cost, [18:6] disparity, [30:19] pixel_column, [31] zero
  output logic [chd_pkg::OUT_W-1:0]        m_axis_tdata,
  output logic                             m_axis_tlast   // last_of_pixel
);
  import chd_pkg::*;

  localparam int XW = $clog2(MAX_ROW_WIDTH);
  localparam int KW = (DISPARITIES_PER_PIXEL > 1) ? $clog2(DISPARITIES_PER_PIXEL) : 1;

  seq_state_t          state;
  seq_state_t          state_next;
  logic [ROWLEN_W-1:0] row_length;
  logic [FIRSTD_W-1:0] first_disparity;
  logic [XW-1:0]       column_counter;
  logic                left_phase;
  logic [CENSUS_W-1:0] left_word;
  logic [XW-1:0]       pix_x;
  logic [KW-1:0]       offset;

  logic                p1_valid;
  logic                p1_off_edge;
  logic [DISP_W-1:0]   p1_disp;
  logic [COL_W-1:0]    p1_col;
  logic                p1_last;

  logic [LEN_W-1:0]    eff_len;
  logic                row_last;
  logic                in_take;
  logic                issue;
  logic                issue_ok;
  logic                last_offset;
  logic [DISP_W-1:0]   disp;
  logic                off_edge;
  logic [XW-1:0]       rd_addr;
  logic [CENSUS_W-1:0] rd_data;
  logic [2:0]          fill_next;
  logic [1:0]          buf_count;
  logic                buf_pop;
  result_t             push_data;
  result_t             out_data;

  // effective row length, clamped to 1..MAX_ROW_WIDTH
  always_comb begin
    if (row_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (LEN_W'(row_length) > LEN_W'(MAX_ROW_WIDTH)) begin
      eff_len = LEN_W'(MAX_ROW_WIDTH);
    end else begin
      eff_len = LEN_W'(row_length);
    end
  end

  assign row_last = (LEN_W'(column_counter) + LEN_W'(1)) >= eff_len;
  assign in_take  = s_axis_tvalid && s_axis_tready;

  // disparity and row store address for the current offset
  assign disp        = DISP_W'(first_disparity) + DISP_W'(offset);
  assign off_edge    = LEN_W'(disp) > LEN_W'(pix_x);
  assign rd_addr     = XW'(LEN_W'(pix_x) - LEN_W'(disp));
  assign last_offset = (offset == KW'(DISPARITIES_PER_PIXEL - 1));

  // room check: a read issued now passes the read stage before it lands in the buffer
  assign buf_pop   = m_axis_tvalid && m_axis_tready;
  assign fill_next = {1'b0, buf_count} + {2'b00, p1_valid} - {2'b00, buf_pop};
  assign issue_ok  = (fill_next <= 3'd1);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_length      <= ROW_LENGTH_RST;
      first_disparity <= FIRST_DISP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_LENGTH: row_length      <= cfg_data;
        REG_FIRST_DISP: first_disparity <= cfg_data[FIRSTD_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      ST_TAKE: begin
        if (in_take && left_phase) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (issue && last_offset) begin
          state_next = ST_TAKE;
        end
      end
      default: state_next = ST_TAKE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    issue         = 1'b0;
    case (state)
      ST_TAKE: s_axis_tready = !rst;
      ST_EMIT: issue         = issue_ok;
      default: ;
    endcase
  end

  // control state: sequencer state, phase, column, offset, read stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_TAKE;
      column_counter <= '0;
      left_phase     <= 1'b0;
      offset         <= '0;
      p1_valid       <= 1'b0;
    end else begin
      state    <= state_next;
      p1_valid <= issue;
      if (in_take) begin
        if (row_last) begin
          column_counter <= '0;
          left_phase     <= ~left_phase;
        end else begin
          column_counter <= column_counter + XW'(1);
        end
        offset <= '0;
      end else if (issue) begin
        offset <= offset + KW'(1);
      end
    end
  end

  // pixel payload and read stage fields
  always_ff @(posedge clk) begin
    if (in_take) begin
      left_word <= s_axis_tdata;
      pix_x     <= column_counter;
    end
    if (issue) begin
      p1_off_edge <= off_edge;
      p1_disp     <= disp;
      p1_col      <= COL_W'(pix_x);
      p1_last     <= last_offset;
    end
  end

  // right row store; writes happen only in ST_TAKE and reads only in ST_EMIT, so never overlap
  chd_ram #(
    .WIDTH (CENSUS_W),
    .DEPTH (MAX_ROW_WIDTH)
  ) u_row_store (
    .clk   (clk),
    .we    (in_take && !left_phase),
    .waddr (column_counter),
    .wdata (s_axis_tdata),
    .re    (issue),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // hamming cost of the returned entry
  always_comb begin
    push_data.pixel_column  = p1_col;
    push_data.disparity     = p1_disp;
    push_data.last_of_pixel = p1_last;
    push_data.match_cost    = p1_off_edge ? COST_OFF_EDGE : popcount48(left_word ^ rd_data);
  end

  chd_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (p1_valid),
    .push_data (push_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data),
    .count     (buf_count)
  );

  assign m_axis_tdata = {1'b0, out_data.pixel_column, out_data.disparity, out_data.match_cost};
  assign m_axis_tlast = out_data.last_of_pixel;

endmodule

### rtl/core/chd_checker.sv
module chd_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [chd_pkg::OUT_W-1:0] m_axis_tdata,
  input logic                      m_axis_tlast
);
  import chd_pkg::*;

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // a cost never exceeds the off-edge cost of 48
  a_cost_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[COST_W-1:0] <= COST_OFF_EDGE))
    else $error("cost out of range");

  // padding bit stays clear
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[OUT_W-1] == 1'b0))
    else $error("padding bit set");

  // reset empties the output buffer
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result present after reset");

endmodule

bind census_hamming_disparity_cost_unit chd_checker u_chd_checker (.*);
